// ===== design/aes128_pkg.sv =====
// shared types, constants and round functions for the aes-128 encrypt core
`timescale 1ns / 1ps

package aes128_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_HALF_W  = 64;
    localparam int CFG_IDX_W   = 1;

    typedef logic [127:0] t_block;
    typedef logic [31:0]  t_word;
    typedef logic [7:0]   t_byte;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx CFG_KEY_HIGH = 1'd0;
    localparam t_cfg_idx CFG_KEY_LOW  = 1'd1;

    localparam t_byte GF_POLY = 8'h1b;

    localparam t_byte RCON [ROUND_COUNT] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam t_byte SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // byte 0 sits in the top bits
    function automatic t_byte get_byte(input t_block b, input int idx);
        return b[127 - 8 * idx -: 8];
    endfunction

    function automatic t_byte xtime(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[get_byte(s, 4 * ((c + r) % 4) + r)];
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block t;
        t_byte  a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4 * c);
            a1  = get_byte(s, 4 * c + 1);
            a2  = get_byte(s, 4 * c + 2);
            a3  = get_byte(s, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c      -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[127 - 32 * c - 8  -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[127 - 32 * c - 16 -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[127 - 32 * c - 24 -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic t_block next_round_key(input t_block k, input t_byte rcon);
        t_word tw, w0, w1, w2, w3;
        tw = {SBOX[get_byte(k, 13)] ^ rcon, SBOX[get_byte(k, 14)],
              SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
        w0 = k[127:96] ^ tw;
        w1 = k[95:64]  ^ w0;
        w2 = k[63:32]  ^ w1;
        w3 = k[31:0]   ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== design/aes_plain_if.sv =====
// stream channel carrying one plaintext block per item
`timescale 1ns / 1ps

interface aes_plain_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_high;
    logic [63:0] plain_low;

    modport source (output valid, output plain_high, output plain_low, input ready);
    modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

// ===== design/aes_cipher_if.sv =====
// stream channel carrying one ciphertext block per item
`timescale 1ns / 1ps

interface aes_cipher_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;

    modport source (output valid, output cipher_high, output cipher_low, input ready);
    modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

// ===== design/aes128_block_encrypt_core.sv =====
// aes-128 encrypt core: eleven-stage round pipeline with on-the-fly key schedule
//
//  channel    dir  handshake      payload
//  i_plain    in   valid/ready    plain_high, plain_low (64 b each)
//  o_cipher   out  valid/ready    cipher_high, cipher_low (64 b each)
//  i_cfg_*    in   write enable   i_cfg_idx selects key_high / key_low, i_cfg_data 64 b
//
//  one item per cycle sustained while o_cipher.ready stays high; an accepted item passes stages 0..10 to o_cipher.valid
//  (stage 0 does the first key add, stages 1..10 one round each with its round key)
//  each stage holds its own block; stages 0..9 also hold the round key the next stage expands from
//  i_rst_n (sync, active low) empties the pipeline and clears the key to zero
//  a stall fills bubbles first; i_plain.ready drops only when every stage is full
`timescale 1ns / 1ps

module aes128_block_encrypt_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aes128_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [aes128_pkg::KEY_HALF_W-1:0]   i_cfg_data,
    aes_plain_if.sink                           i_plain,
    aes_cipher_if.source                        o_cipher
);

    localparam int NR = aes128_pkg::ROUND_COUNT;

    logic [aes128_pkg::KEY_HALF_W-1:0] r_key_high;
    logic [aes128_pkg::KEY_HALF_W-1:0] r_key_low;

    aes128_pkg::t_block r_state [0:NR];
    aes128_pkg::t_block r_key   [0:NR-1];
    logic [NR:0]        r_vld;

    aes128_pkg::t_block n_state [0:NR];
    aes128_pkg::t_block n_key   [0:NR];
    logic [NR:0]        src_vld;
    logic [NR:0]        ld;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aes128_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes128_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        ld[NR] = !r_vld[NR] || o_cipher.ready;
        for (int i = NR - 1; i >= 0; i--) begin
            ld[i] = !r_vld[i] || ld[i + 1];
        end
    end

    assign src_vld = {r_vld[NR-1:0], i_plain.valid};

    // initial key add
    assign n_key[0]   = {r_key_high, r_key_low};
    assign n_state[0] = {i_plain.plain_high, i_plain.plain_low} ^ n_key[0];

    for (genvar g = 1; g <= NR; g++) begin : g_round
        aes128_pkg::t_block shifted;
        aes128_pkg::t_block mixed;
        assign n_key[g] = aes128_pkg::next_round_key(r_key[g-1], aes128_pkg::RCON[g-1]);
        assign shifted  = aes128_pkg::sub_shift(r_state[g-1]);
        // last round skips the column mix
        assign mixed    = (g == NR) ? shifted : aes128_pkg::mix_columns(shifted);
        assign n_state[g] = mixed ^ n_key[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i <= NR; i++) begin
                if (ld[i]) begin
                    r_vld[i] <= src_vld[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= NR; i++) begin
            if (ld[i] && src_vld[i]) begin
                r_state[i] <= n_state[i];
            end
        end
        for (int i = 0; i < NR; i++) begin
            if (ld[i] && src_vld[i]) begin
                r_key[i] <= n_key[i];
            end
        end
    end

    assign i_plain.ready        = ld[0];
    assign o_cipher.valid       = r_vld[NR];
    assign o_cipher.cipher_high = r_state[NR][127:64];
    assign o_cipher.cipher_low  = r_state[NR][63:0];

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_plain.valid && i_plain.ready |=> r_vld[0])
        else $error("accepted item did not enter stage 0");

    a_last_round_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NR-1] && ld[NR] |=> r_vld[NR])
        else $error("item lost between last round and output");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_plain.ready |-> (&r_vld) && !o_cipher.ready)
        else $error("input blocked while the pipeline has a bubble");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cipher.valid && !o_cipher.ready |=> o_cipher.valid && $stable(r_state[NR]))
        else $error("waiting output item changed");

endmodule

// ===== tb/sv/aes128_cipher_monitor.sv =====
// watches the key writes and both channels, predicts each ciphertext and compares it
`timescale 1ns / 1ps

module aes128_cipher_monitor (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  aes128_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  logic                  i_plain_valid,
    input  logic                  i_plain_ready,
    input  logic [63:0]           i_plain_high,
    input  logic [63:0]           i_plain_low,
    input  logic                  i_cipher_valid,
    input  logic                  i_cipher_ready,
    input  logic [63:0]           i_cipher_high,
    input  logic [63:0]           i_cipher_low,
    output int                    o_fail_count,
    output int                    o_pending_count,
    output int                    o_checked_count
);

    localparam logic [7:0] GF_REDUCE = 8'h1b;
    localparam logic [7:0] AFFINE_C  = 8'h63;

    logic [7:0]   sbox_tab [256];
    logic [63:0]  key_high;
    logic [63:0]  key_low;
    logic [127:0] pending_ciphers [$];
    int           mismatch_cnt;
    int           pending_cnt;
    int           checked_cnt;
    logic         kat_bad;

    assign o_fail_count    = mismatch_cnt + int'(kat_bad);
    assign o_pending_count = pending_cnt;
    assign o_checked_count = checked_cnt;

    function automatic logic [7:0] times_x(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
    endfunction

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] m;
        int         i;
        p = 8'h00;
        m = a;
        for (i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ m;
            m = times_x(m);
        end
        return p;
    endfunction

    // multiplicative inverse as x^254, then the affine map
    function automatic logic [7:0] sbox_entry(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] base;
        int         i;
        inv  = 8'h01;
        base = x;
        for (i = 0; i < 8; i++) begin
            if ((254 >> i) & 1) inv = gf_product(inv, base);
            base = gf_product(base, base);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                   ^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                   input logic [127:0] plain);
        logic [7:0]   st [16];
        logic [7:0]   rk [16];
        logic [7:0]   sh [16];
        logic [7:0]   tw [4];
        logic [7:0]   rc, a0, a1, a2, a3, col_x;
        logic [127:0] res;
        int           i, c, r, rnd;
        for (i = 0; i < 16; i++) begin
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = plain[127 - 8 * i -: 8] ^ rk[i];
        end
        rc = 8'h01;
        for (rnd = 1; rnd <= aes128_pkg::ROUND_COUNT; rnd++) begin
            // sub bytes and shift rows in one pass, column-major state
            for (c = 0; c < 4; c++) begin
                for (r = 0; r < 4; r++) begin
                    sh[4 * c + r] = sbox_tab[st[4 * ((c + r) & 3) + r]];
                end
            end
            st = sh;
            if (rnd < aes128_pkg::ROUND_COUNT) begin
                for (c = 0; c < 4; c++) begin
                    a0 = st[4 * c];
                    a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2];
                    a3 = st[4 * c + 3];
                    col_x = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c]     = a0 ^ col_x ^ times_x(a0 ^ a1);
                    st[4 * c + 1] = a1 ^ col_x ^ times_x(a1 ^ a2);
                    st[4 * c + 2] = a2 ^ col_x ^ times_x(a2 ^ a3);
                    st[4 * c + 3] = a3 ^ col_x ^ times_x(a3 ^ a0);
                end
            end
            // key schedule: rot, sub and rcon on the last word
            tw[0] = sbox_tab[rk[13]] ^ rc;
            tw[1] = sbox_tab[rk[14]];
            tw[2] = sbox_tab[rk[15]];
            tw[3] = sbox_tab[rk[12]];
            for (i = 0; i < 4; i++) rk[i] = rk[i] ^ tw[i];
            for (i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i - 4];
            rc = times_x(rc);
            for (i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
        end
        for (i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    initial begin
        logic [127:0] kat;
        kat_bad = 1'b0;
        for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_entry(8'(i));
        // sanity check of the predictor against the published example vector
        kat = encrypt_block(128'h000102030405060708090a0b0c0d0e0f,
                            128'h00112233445566778899aabbccddeeff);
        if (kat !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a) begin
            $display("%0t: predictor known-answer mismatch: expected %h actual %h",
                     $time, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, kat);
            kat_bad = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [127:0] want;
        if (!i_rst_n) begin
            key_high = '0;
            key_low  = '0;
            pending_ciphers.delete();
            mismatch_cnt = 0;
            checked_cnt  = 0;
        end else begin
            if (i_cipher_valid && i_cipher_ready) begin
                if (pending_ciphers.size() == 0) begin
                    $display("%0t: cipher item with no block pending: actual %h_%h",
                             $time, i_cipher_high, i_cipher_low);
                    mismatch_cnt++;
                end else begin
                    want = pending_ciphers.pop_front();
                    checked_cnt++;
                    if (i_cipher_high !== want[127:64]) begin
                        $display("%0t: cipher_high mismatch: expected %h actual %h",
                                 $time, want[127:64], i_cipher_high);
                        mismatch_cnt++;
                    end
                    if (i_cipher_low !== want[63:0]) begin
                        $display("%0t: cipher_low mismatch: expected %h actual %h",
                                 $time, want[63:0], i_cipher_low);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_plain_valid && i_plain_ready) begin
                pending_ciphers.push_back(encrypt_block({key_high, key_low},
                                                        {i_plain_high, i_plain_low}));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aes128_pkg::CFG_KEY_HIGH: key_high = i_cfg_data;
                    aes128_pkg::CFG_KEY_LOW:  key_low  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending_cnt <= pending_ciphers.size();
    end

endmodule

// ===== tb/sv/tb_aes128_block_encrypt_core.sv =====
// top of the aes-128 encrypt core testbench: clock, reset, key writes and block stimulus
`timescale 1ns / 1ps

module tb_aes128_block_encrypt_core;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    aes128_pkg::t_cfg_idx  cfg_idx;
    logic [63:0]           cfg_data;

    logic        tx_steady;
    logic        rx_steady;
    int          fail_count;
    int          pending_count;
    int          checked_count;
    int          blocks_sent;
    int          key_settings;

    aes_plain_if  plain_ch ();
    aes_cipher_if cipher_ch ();

    aes128_block_encrypt_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_plain    (plain_ch),
        .o_cipher   (cipher_ch)
    );

    aes128_cipher_monitor cipher_mon (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_plain_valid   (plain_ch.valid),
        .i_plain_ready   (plain_ch.ready),
        .i_plain_high    (plain_ch.plain_high),
        .i_plain_low     (plain_ch.plain_low),
        .i_cipher_valid  (cipher_ch.valid),
        .i_cipher_ready  (cipher_ch.ready),
        .i_cipher_high   (cipher_ch.cipher_high),
        .i_cipher_low    (cipher_ch.cipher_low),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver: ready held high while rx_steady, else high or low for random stretches
    initial begin
        int rx_left;
        int pick;
        rx_left = 0;
        cipher_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_steady) begin
                cipher_ch.ready <= 1'b1;
            end else if (rx_left == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    cipher_ch.ready <= 1'b1;
                    rx_left = $urandom_range(1, 20);
                end else if (pick < 92) begin
                    cipher_ch.ready <= 1'b0;
                    rx_left = $urandom_range(1, 3);
                end else begin
                    cipher_ch.ready <= 1'b0;
                    rx_left = $urandom_range(10, 40);
                end
            end else begin
                rx_left--;
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_steady || pick < 65) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] rand_half();
        return {$urandom, $urandom};
    endfunction

    // valid stays high into the next item when there is no gap
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            plain_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        plain_ch.valid      <= 1'b1;
        plain_ch.plain_high <= hi;
        plain_ch.plain_low  <= lo;
        @(posedge i_clk);
        while (!plain_ch.ready) @(posedge i_clk);
        blocks_sent++;
    endtask

    task automatic drain_pipe();
        plain_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
        cfg_we   <= 1'b1;
        cfg_idx  <= aes128_pkg::CFG_KEY_HIGH;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_idx  <= aes128_pkg::CFG_KEY_LOW;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        key_settings++;
    endtask

    task automatic write_one(input aes128_pkg::t_cfg_idx idx, input logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        key_settings++;
    endtask

    // mostly random blocks with an occasional extreme pattern
    task automatic send_random(input int count);
        int k;
        int pick;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) send_block('1, '1);
            else if (pick < 8) send_block('0, '0);
            else if (pick < 12) send_block(64'd1 << $urandom_range(0, 63), '0);
            else send_block(rand_half(), rand_half());
            // hold off now and then until the pipeline is empty
            if ($urandom_range(0, 39) == 0) drain_pipe();
        end
    endtask

    initial begin
        int ph;
        blocks_sent  = 0;
        key_settings = 1;
        tx_steady    = 1'b1;
        rx_steady    = 1'b1;
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= aes128_pkg::CFG_KEY_HIGH;
        cfg_data            <= '0;
        plain_ch.valid      <= 1'b0;
        plain_ch.plain_high <= '0;
        plain_ch.plain_low  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero key straight out of reset, back-to-back items
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_block(64'h8000000000000000, 64'h0000000000000000);
        send_block(64'h0000000000000000, 64'h0000000000000001);
        drain_pipe();

        // published example key
        write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('0, '0);
        send_block('1, '1);
        drain_pipe();

        // all-ones key, then only the low half cleared
        write_key('1, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain_pipe();
        write_one(aes128_pkg::CFG_KEY_LOW, '0);
        send_block('0, '0);
        send_block(64'hdeadbeef01234567, 64'h89abcdeffedcba98);
        drain_pipe();

        // random keys and blocks; each side idles at random unless held steady
        for (ph = 0; ph < 5; ph++) begin
            tx_steady = (ph == 1);
            rx_steady = (ph == 1) || (ph == 3 && $urandom_range(0, 1) == 1);
            if (ph == 2) write_one(aes128_pkg::CFG_KEY_HIGH, rand_half());
            else write_key(rand_half(), rand_half());
            send_random(80);
            drain_pipe();
        end

        repeat (20) @(posedge i_clk);
        $display("run covered %0d blocks under %0d key settings, zero and all-ones keys included",
                 blocks_sent, key_settings);
        $display("%0d cipher items checked against the predicted ciphertext", checked_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
